// ===== design/pakf_pkg.sv =====
// ----------------------------------------------------------------------------
// pakf_pkg
// Shared types, constants and color helper functions for the palette alpha
// key filter.
// ----------------------------------------------------------------------------
package pakf_pkg;

    // Default palette size; the top level hands it down as a parameter.
    localparam int unsigned PaletteEntriesDefault = 256;

    // Field widths.
    localparam int unsigned ColorW    = 16;
    localparam int unsigned ChanW     = 5;
    localparam int unsigned SquareW   = 2 * ChanW;
    localparam int unsigned Dist2W    = SquareW + 2;
    localparam int unsigned IndexW    = 8;
    localparam int unsigned CountW    = 9;
    localparam int unsigned NumPlanes = 6;

    // Channel positions inside a color; bit 5 is unused.
    localparam int unsigned BlueLsb  = 0;
    localparam int unsigned GreenLsb = 6;
    localparam int unsigned RedLsb   = 11;

    // Decision thresholds.
    localparam logic [Dist2W-1:0] DarkLimit  = Dist2W'(32);
    localparam logic [Dist2W-1:0] MatchLimit = Dist2W'(16);

    // Configuration port.
    localparam int unsigned ApbAddrW = 1;
    localparam int unsigned ApbDataW = 32;
    localparam logic [ApbAddrW-1:0] AddrFilterEnable = ApbAddrW'(0);

    typedef logic [ColorW-1:0] t_color;
    typedef logic [ChanW-1:0]  t_chan;

    // One input item as held in the input register.
    typedef struct packed {
        t_color                 base;
        t_color [NumPlanes-1:0] planes;
        t_color                 repl;
    } t_item;

    // Palette summary carried with each result.
    typedef struct packed {
        logic              last;
        logic [IndexW-1:0] total;
        logic [IndexW-1:0] first;
        logic              any;
        logic              write;
    } t_summary;

    // Extract one 5-bit channel starting at the given bit.
    function automatic t_chan chan(t_color c, int unsigned lsb);
        chan = t_chan'(c >> lsb);
    endfunction

    // Square of the absolute difference of two channels.
    function automatic logic [SquareW-1:0] sq_diff(t_chan a, t_chan b);
        t_chan d;
        d = (a >= b) ? (a - b) : (b - a);
        sq_diff = SquareW'(d) * SquareW'(d);
    endfunction

    // Squared channel distance between two colors.
    function automatic logic [Dist2W-1:0] dist2(t_color a, t_color b);
        dist2 = Dist2W'(sq_diff(chan(a, BlueLsb), chan(b, BlueLsb)))
              + Dist2W'(sq_diff(chan(a, GreenLsb), chan(b, GreenLsb)))
              + Dist2W'(sq_diff(chan(a, RedLsb), chan(b, RedLsb)));
    endfunction

endpackage

// ===== design/pakf_if.sv =====
// ----------------------------------------------------------------------------
// pakf_if
// Valid/ready channels for palette entries and filter results.
// ----------------------------------------------------------------------------

// Entry channel: one palette entry with its six shade planes.
interface pakf_in_if;
    import pakf_pkg::*;

    logic   valid;
    logic   ready;
    t_color base_color;
    t_color plane1_color;
    t_color plane2_color;
    t_color plane3_color;
    t_color plane4_color;
    t_color plane5_color;
    t_color plane6_color;
    t_color replacement_color;

    modport source (
        output valid, base_color, plane1_color, plane2_color, plane3_color,
               plane4_color, plane5_color, plane6_color, replacement_color,
        input  ready
    );
    modport sink (
        input  valid, base_color, plane1_color, plane2_color, plane3_color,
               plane4_color, plane5_color, plane6_color, replacement_color,
        output ready
    );
endinterface

// Result channel: filtered entry plus palette summary.
interface pakf_out_if;
    import pakf_pkg::*;

    logic              valid;
    logic              ready;
    t_color            entry_value;
    logic              entry_cleared;
    logic              last;
    logic [IndexW-1:0] cleared_total;
    logic [IndexW-1:0] first_cleared_index;
    logic              any_cleared;
    logic              write_summary;

    modport source (
        output valid, entry_value, entry_cleared, last, cleared_total,
               first_cleared_index, any_cleared, write_summary,
        input  ready
    );
    modport sink (
        input  valid, entry_value, entry_cleared, last, cleared_total,
               first_cleared_index, any_cleared, write_summary,
        output ready
    );
endinterface

// ===== design/pakf_classify.sv =====
// ----------------------------------------------------------------------------
// pakf_classify
// Decides whether one palette entry is cleared, replaced or passed through.
// ----------------------------------------------------------------------------
module pakf_classify (
    input  logic            i_enable,
    input  pakf_pkg::t_item i_item,
    output pakf_pkg::t_color o_value,
    output logic            o_cleared
);
    import pakf_pkg::*;

    logic                 dark;
    logic [NumPlanes-1:0] far;
    logic [Dist2W-1:0]    norm;

    // Brightness test: squared length of the base color.
    always_comb begin
        norm = dist2(i_item.base, '0);
        dark = norm < DarkLimit;
    end

    // Plane tests are independent; any far plane clears the entry.
    always_comb begin
        for (int k = 0; k < NumPlanes; k++) begin
            far[k] = dist2(i_item.planes[k], i_item.base) > MatchLimit;
        end
    end

    // Select the new entry value.
    always_comb begin
        o_cleared = i_enable && (dark || (|far));
        if (!i_enable) begin
            o_value = i_item.base;
        end else if (o_cleared) begin
            o_value = '0;
        end else begin
            o_value = i_item.repl;
        end
    end

endmodule

// ===== design/pakf_tally.sv =====
// ----------------------------------------------------------------------------
// pakf_tally
// Tracks the entry position, the cleared count and the first cleared index,
// and forms the palette summary on the last entry.
// ----------------------------------------------------------------------------
module pakf_tally #(
    parameter int unsigned PaletteEntries = pakf_pkg::PaletteEntriesDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_enable,
    input  logic               i_cleared,
    output pakf_pkg::t_summary o_summary
);
    import pakf_pkg::*;

    localparam logic [IndexW-1:0] LastPos      = IndexW'(PaletteEntries - 1);
    localparam logic [CountW-1:0] EntriesCount = CountW'(PaletteEntries);

    logic [IndexW-1:0] r_pos;
    logic [CountW-1:0] r_count;
    logic [IndexW-1:0] r_first;
    logic              r_first_valid;

    logic [CountW-1:0] n_count;
    logic [IndexW-1:0] n_first;
    logic              n_first_valid;
    logic              hit;
    logic              is_last;

    // Running values including the current entry.
    always_comb begin
        hit           = i_enable && i_cleared;
        n_count       = r_count + CountW'(hit);
        n_first       = (hit && !r_first_valid) ? r_pos : r_first;
        n_first_valid = r_first_valid || hit;
        is_last       = r_pos >= LastPos;
    end

    // Summary fields other than last are zero except on the last entry with the filter on.
    always_comb begin
        o_summary      = '0;
        o_summary.last = is_last;
        if (is_last && i_enable) begin
            o_summary.total = (n_count >= EntriesCount) ? '0 : n_count[IndexW-1:0];
            o_summary.first = n_first_valid ? n_first : '0;
            o_summary.any   = n_first_valid;
            o_summary.write = 1'b1;
        end
    end

    // Counters restart after the last entry of each palette.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_count       <= '0;
            r_first       <= '0;
            r_first_valid <= 1'b0;
        end else if (i_advance) begin
            if (is_last) begin
                r_pos         <= '0;
                r_count       <= '0;
                r_first       <= '0;
                r_first_valid <= 1'b0;
            end else begin
                r_pos         <= r_pos + 1'b1;
                r_count       <= n_count;
                r_first       <= n_first;
                r_first_valid <= n_first_valid;
            end
        end
    end

endmodule

// ===== design/palette_alpha_key_filter.sv =====
// ----------------------------------------------------------------------------
// palette_alpha_key_filter
// Alpha key filter over palette entries with summary on the last entry.
// ----------------------------------------------------------------------------
// Path: an accepted entry is held in the input register, then its result in
// the result register, once that register is free.
// Throughput: one entry per cycle while results are taken; while a finished
// result waits for ready, the input register can still take one new entry.
// Reset: synchronous, active low; clears both valid flags, the entry counters
// and the filter enable.
module palette_alpha_key_filter #(
    parameter int unsigned PaletteEntries = pakf_pkg::PaletteEntriesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pakf_in_if.sink                        i_in,
    pakf_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pakf_pkg::ApbAddrW-1:0]  paddr,
    input  logic [pakf_pkg::ApbDataW-1:0]  pwdata,
    output logic [pakf_pkg::ApbDataW-1:0]  prdata,
    output logic                           pready
);
    import pakf_pkg::*;

    logic     r_enable;
    logic     r_s1_valid;
    t_item    r_s1_item;
    logic     r_out_valid;
    t_color   r_out_value;
    logic     r_out_cleared;
    t_summary r_out_summary;

    logic     out_free;
    logic     s1_advance;
    t_color   cls_value;
    logic     cls_cleared;
    t_summary summary;

    // Configuration register: written in the APB access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == AddrFilterEnable) ? ApbDataW'(r_enable) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == AddrFilterEnable)) begin
            r_enable <= pwdata[0];
        end
    end

    // Handshake: the result register frees up when empty or being taken.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_item.base      <= i_in.base_color;
            r_s1_item.planes[0] <= i_in.plane1_color;
            r_s1_item.planes[1] <= i_in.plane2_color;
            r_s1_item.planes[2] <= i_in.plane3_color;
            r_s1_item.planes[3] <= i_in.plane4_color;
            r_s1_item.planes[4] <= i_in.plane5_color;
            r_s1_item.planes[5] <= i_in.plane6_color;
            r_s1_item.repl      <= i_in.replacement_color;
        end
    end

    // Entry decision.
    pakf_classify u_classify (
        .i_enable  (r_enable),
        .i_item    (r_s1_item),
        .o_value   (cls_value),
        .o_cleared (cls_cleared)
    );

    // Palette bookkeeping, updated as each entry moves to the result register.
    pakf_tally #(
        .PaletteEntries (PaletteEntries)
    ) u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_advance),
        .i_enable  (r_enable),
        .i_cleared (cls_cleared),
        .o_summary (summary)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_value   <= cls_value;
            r_out_cleared <= cls_cleared;
            r_out_summary <= summary;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.entry_value         = r_out_value;
    assign o_out.entry_cleared       = r_out_cleared;
    assign o_out.last                = r_out_summary.last;
    assign o_out.cleared_total       = r_out_summary.total;
    assign o_out.first_cleared_index = r_out_summary.first;
    assign o_out.any_cleared         = r_out_summary.any;
    assign o_out.write_summary       = r_out_summary.write;

endmodule

// ===== design/pakf_checker.sv =====
// ----------------------------------------------------------------------------
// pakf_checker
// Port-level checks on the result channel of the palette alpha key filter.
// ----------------------------------------------------------------------------
module pakf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [pakf_pkg::ColorW-1:0] i_entry_value,
    input logic                        i_entry_cleared,
    input logic                        i_last,
    input logic [pakf_pkg::IndexW-1:0] i_cleared_total,
    input logic [pakf_pkg::IndexW-1:0] i_first_cleared_index,
    input logic                        i_any_cleared,
    input logic                        i_write_summary
);
    import pakf_pkg::*;

    // A pending result stays until the sink takes it.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // A cleared entry always reads as zero.
    a_cleared_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_entry_cleared |-> i_entry_value == '0)
        else $error("cleared entry has nonzero value");

    // Summary fields are only driven on the last entry.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> !i_write_summary && !i_any_cleared
                               && i_cleared_total == '0 && i_first_cleared_index == '0)
        else $error("summary outside last entry");

    // Flags of a cleared palette only appear with a written summary.
    a_any_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_any_cleared |-> i_write_summary)
        else $error("cleared flag without summary write");

    // With no entry cleared, the first index reads as zero.
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_any_cleared |-> i_first_cleared_index == '0)
        else $error("first index set with nothing cleared");

endmodule

bind palette_alpha_key_filter pakf_checker u_pakf_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_valid               (o_out.valid),
    .i_ready               (o_out.ready),
    .i_entry_value         (o_out.entry_value),
    .i_entry_cleared       (o_out.entry_cleared),
    .i_last                (o_out.last),
    .i_cleared_total       (o_out.cleared_total),
    .i_first_cleared_index (o_out.first_cleared_index),
    .i_any_cleared         (o_out.any_cleared),
    .i_write_summary       (o_out.write_summary)
);

// ===== tb/palette_alpha_key_filter_tb.sv =====
// ----------------------------------------------------------------------------
// palette_alpha_key_filter_tb
// Self-checking regression for the palette alpha key filter. A clocked driver
// feeds palette entries from a queue while a clocked monitor accepts results
// with random back-pressure. Each accepted entry is run through a local
// predictor that tracks the palette position, the cleared count and the first
// cleared index, and every result word is checked field by field. The run
// walks through directed corner entries, an all-cleared palette, a palette
// with nothing cleared, and random phases of mixed entries with the filter
// enable toggled between phases.
// ----------------------------------------------------------------------------
module palette_alpha_key_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pakf_pkg::*;

    localparam int unsigned PaletteSize   = PaletteEntriesDefault;
    localparam int unsigned TargetEntries = 1450;
    localparam int unsigned LongHold      = 150;
    localparam int unsigned LongHoldAt    = 400;
    localparam int unsigned WatchdogLimit = 5000;
    localparam int unsigned DarkThreshold = 32;
    localparam int unsigned NearThreshold = 16;

    // Expected content of one result word.
    typedef struct packed {
        t_color            value;
        logic              cleared;
        logic              last;
        logic [IndexW-1:0] total;
        logic [IndexW-1:0] first;
        logic              any;
        logic              wr;
    } t_filtered;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    pakf_in_if  entry_ch ();
    pakf_out_if result_ch ();

    palette_alpha_key_filter #(
        .PaletteEntries(PaletteSize)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (entry_ch),
        .o_out   (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Entries waiting to be offered and results still owed by the block.
    t_item       pending_q[$];
    t_filtered   filtered_q[$];
    t_item       cur_entry;
    int unsigned items_queued;
    int unsigned entries_accepted;
    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned send_gap;
    int unsigned recv_hold;
    int unsigned idle_cycles;
    bit          long_hold_done;

    // Predictor copy of the block's state and of the enable register.
    bit                filter_on;
    logic [IndexW-1:0] palette_pos;
    logic [CountW-1:0] clear_count;
    logic [IndexW-1:0] first_clear_idx;
    bit                first_clear_seen;

    // Squared channel distance between two colors; bit 5 does not count.
    function automatic int color_dist(t_color a, t_color b);
        int db;
        int dg;
        int dr;
        db = int'(a[4:0]) - int'(b[4:0]);
        dg = int'(a[10:6]) - int'(b[10:6]);
        dr = int'(a[15:11]) - int'(b[15:11]);
        return db * db + dg * dg + dr * dr;
    endfunction

    // Work out the result word for one accepted entry and advance the state.
    function automatic t_filtered screen_entry(t_item e);
        t_filtered res;
        bit        clr;
        int        k;
        res = '0;
        clr = 1'b0;
        res.value = e.base;
        if (filter_on) begin
            if (color_dist(e.base, 16'h0000) < DarkThreshold) begin
                clr = 1'b1;
            end else begin
                for (k = 0; k < NumPlanes; k++) begin
                    if (!clr && color_dist(e.planes[k], e.base) > NearThreshold) begin
                        clr = 1'b1;
                    end
                end
            end
            if (clr) begin
                res.value = '0;
                clear_count = clear_count + 1'b1;
                if (!first_clear_seen) begin
                    first_clear_idx  = palette_pos;
                    first_clear_seen = 1'b1;
                end
            end else begin
                res.value = e.repl;
            end
        end
        res.cleared = clr;
        res.last = (palette_pos == IndexW'(PaletteSize - 1));
        if (res.last) begin
            if (filter_on) begin
                res.total = (clear_count >= PaletteSize) ? '0 : clear_count[IndexW-1:0];
                res.first = first_clear_seen ? first_clear_idx : '0;
                res.any   = first_clear_seen;
                res.wr    = 1'b1;
            end
            palette_pos      = '0;
            clear_count      = '0;
            first_clear_idx  = '0;
            first_clear_seen = 1'b0;
        end else begin
            palette_pos = palette_pos + 1'b1;
        end
        return res;
    endfunction

    // Mostly no pause, sometimes a short one, rarely a long one; none when calm.
    function automatic int unsigned pick_pause(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic t_color pack_rgb(int r, int g, int b, bit spare);
        t_color c;
        c[15:11] = 5'(r);
        c[10:6]  = 5'(g);
        c[5]     = spare;
        c[4:0]   = 5'(b);
        return c;
    endfunction

    // Move a channel by a random amount within the spread, clamped to 0..31.
    function automatic int shift_chan(logic [4:0] ch, int spread);
        int v;
        v = int'(ch) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end else if (v > 31) begin
            v = 31;
        end
        return v;
    endfunction

    function automatic t_color near_color(t_color c, int spread);
        return pack_rgb(shift_chan(c[15:11], spread), shift_chan(c[10:6], spread),
                        shift_chan(c[4:0], spread), 1'($urandom));
    endfunction

    // Channels of at most 3 keep the sum of squares below the dark threshold.
    function automatic t_color dark_color();
        return pack_rgb($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                        1'($urandom));
    endfunction

    function automatic t_item uniform_entry(t_color base, t_color plane, t_color repl);
        t_item e;
        int    k;
        e.base = base;
        e.repl = repl;
        for (k = 0; k < NumPlanes; k++) begin
            e.planes[k] = plane;
        end
        return e;
    endfunction

    // Bright entry with all planes close by: it always takes the replacement.
    function automatic t_item clean_entry();
        t_item e;
        int    k;
        e.base = pack_rgb($urandom_range(6, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                          1'($urandom));
        e.repl = 16'($urandom);
        for (k = 0; k < NumPlanes; k++) begin
            e.planes[k] = near_color(e.base, 2);
        end
        return e;
    endfunction

    // Mostly well-formed entries with near planes, some dark, some pure noise.
    function automatic t_item mixed_entry();
        t_item       e;
        int unsigned pick;
        int          k;
        pick = $urandom_range(0, 99);
        e.base = 16'($urandom);
        e.repl = 16'($urandom);
        if (pick < 12) begin
            for (k = 0; k < NumPlanes; k++) begin
                e.planes[k] = 16'($urandom);
            end
        end else begin
            if (pick < 22) begin
                e.base = dark_color();
            end
            for (k = 0; k < NumPlanes; k++) begin
                e.planes[k] = near_color(e.base, 2);
            end
            if (pick >= 80) begin
                e.planes[$urandom_range(0, NumPlanes - 1)] = near_color(e.base, 4);
            end
        end
        return e;
    endfunction

    task automatic post_entry(t_item e);
        pending_q.push_back(e);
        items_queued++;
    endtask

    task automatic post_mixed(int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++) begin
            post_entry(mixed_entry());
        end
    endtask

    // Entries still needed to reach the end of the current palette.
    function automatic int unsigned to_palette_end();
        return PaletteSize - (items_queued % PaletteSize);
    endfunction

    task automatic check_field(string name, logic [ColorW-1:0] want, logic [ColorW-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // One APB transfer: setup cycle, then access cycle with pready high.
    task automatic apb_transfer(bit wr, logic [ApbAddrW-1:0] addr,
                                logic [ApbDataW-1:0] wdata,
                                output logic [ApbDataW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        check_field("pready", ColorW'(1'b1), ColorW'(pready));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_filter_reg(bit want);
        logic [ApbDataW-1:0] rd;
        apb_transfer(1'b0, AddrFilterEnable, '0, rd);
        check_field("filter_enable", ColorW'(want), ColorW'(rd));
    endtask

    task automatic set_filter(bit on);
        logic [ApbDataW-1:0] rd;
        apb_transfer(1'b1, AddrFilterEnable, ApbDataW'(on), rd);
        filter_on = on;
        check_filter_reg(on);
    endtask

    // Hold off until every queued entry went in and every result came out.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || entry_ch.valid || filtered_q.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Sender: offers queued entries with random gaps and predicts on accept.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (entry_ch.valid && entry_ch.ready) begin
                filtered_q.push_back(screen_entry(cur_entry));
                entries_accepted++;
            end
            if (!entry_ch.valid || entry_ch.ready) begin
                if (send_gap > 0) begin
                    entry_ch.valid <= 1'b0;
                    send_gap--;
                end else if (pending_q.size() > 0) begin
                    cur_entry = pending_q.pop_front();
                    entry_ch.base_color        <= cur_entry.base;
                    entry_ch.plane1_color      <= cur_entry.planes[0];
                    entry_ch.plane2_color      <= cur_entry.planes[1];
                    entry_ch.plane3_color      <= cur_entry.planes[2];
                    entry_ch.plane4_color      <= cur_entry.planes[3];
                    entry_ch.plane5_color      <= cur_entry.planes[4];
                    entry_ch.plane6_color      <= cur_entry.planes[5];
                    entry_ch.replacement_color <= cur_entry.repl;
                    entry_ch.valid             <= 1'b1;
                    send_gap = pick_pause(((entries_accepted / 128) % 4) == 1);
                end else begin
                    entry_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and applies back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (filtered_q.size() == 0) begin
                    $error("result word with no entry outstanding");
                    fail_count++;
                end else begin
                    t_filtered want;
                    want = filtered_q.pop_front();
                    check_field("entry_value", want.value, result_ch.entry_value);
                    check_field("entry_cleared", ColorW'(want.cleared),
                                ColorW'(result_ch.entry_cleared));
                    check_field("last", ColorW'(want.last), ColorW'(result_ch.last));
                    check_field("cleared_total", ColorW'(want.total),
                                ColorW'(result_ch.cleared_total));
                    check_field("first_cleared_index", ColorW'(want.first),
                                ColorW'(result_ch.first_cleared_index));
                    check_field("any_cleared", ColorW'(want.any),
                                ColorW'(result_ch.any_cleared));
                    check_field("write_summary", ColorW'(want.wr),
                                ColorW'(result_ch.write_summary));
                end
                results_checked++;
            end
            if (recv_hold > 0) begin
                result_ch.ready <= 1'b0;
                recv_hold--;
            end else if (!long_hold_done && results_checked >= LongHoldAt) begin
                // One long hold-off so the block fills up and stalls its input.
                long_hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                recv_hold = LongHold - 1;
            end else if (result_ch.valid && result_ch.ready) begin
                recv_hold = pick_pause(((results_checked / 100) % 4) == 2);
                if (recv_hold > 0) begin
                    result_ch.ready <= 1'b0;
                    recv_hold--;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((entry_ch.valid && entry_ch.ready)
                     || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("palette_alpha_key_filter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_item  e;
        t_color mid;
        bit     phase_on;

        i_rst_n                    = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        entry_ch.valid             = 1'b0;
        entry_ch.base_color        = '0;
        entry_ch.plane1_color      = '0;
        entry_ch.plane2_color      = '0;
        entry_ch.plane3_color      = '0;
        entry_ch.plane4_color      = '0;
        entry_ch.plane5_color      = '0;
        entry_ch.plane6_color      = '0;
        entry_ch.replacement_color = '0;
        result_ch.ready            = 1'b0;
        items_queued               = 0;
        entries_accepted           = 0;
        results_checked            = 0;
        fail_count                 = 0;
        long_hold_done             = 1'b0;
        filter_on                  = 1'b0;
        palette_pos                = '0;
        clear_count                = '0;
        first_clear_idx            = '0;
        first_clear_seen           = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The enable register comes out of reset cleared.
        check_filter_reg(1'b0);
        set_filter(1'b1);

        // Directed entries with the filter on.
        mid = pack_rgb(16, 16, 16, 1'b0);
        post_entry(uniform_entry(16'h0000, 16'h0000, 16'hFFFF));     // black is dark
        post_entry(uniform_entry(16'hFFFF, 16'hFFFF, 16'h0000));     // white matches
        post_entry(uniform_entry(16'hFFFF, 16'hFFDF, 16'h1234));     // spare bit ignored
        post_entry(uniform_entry(pack_rgb(1, 2, 5, 1'b0), pack_rgb(1, 2, 5, 1'b0),
                                 16'hFFFF));                         // just below dark limit
        post_entry(uniform_entry(pack_rgb(0, 4, 4, 1'b1), pack_rgb(0, 4, 4, 1'b0),
                                 16'h5A5A));                         // exactly at dark limit
        post_entry(uniform_entry(16'h0020, 16'h0020, 16'hFFFF));     // only spare bit set
        post_entry(uniform_entry(mid, pack_rgb(16, 16, 20, 1'b0), 16'hA5A5));
        e = uniform_entry(mid, mid, 16'h7E7E);
        e.planes[2] = pack_rgb(16, 17, 20, 1'b0);                    // one past match limit
        post_entry(e);
        e = uniform_entry(mid, mid, 16'h8181);
        e.planes[0] = 16'h0000;                                      // first plane far
        post_entry(e);
        e = uniform_entry(mid, mid, 16'h8181);
        e.planes[NumPlanes-1] = 16'hFFFF;                            // last plane far
        post_entry(e);
        post_entry(uniform_entry(pack_rgb(31, 31, 31, 1'b1), pack_rgb(27, 31, 31, 1'b0),
                                 16'hFFFF));
        post_entry(uniform_entry(pack_rgb(0, 0, 31, 1'b0), 16'h0000, 16'h1111));
        e = uniform_entry(mid, mid, 16'h0000);
        e.planes[0] = pack_rgb(20, 16, 16, 1'b1);
        e.planes[1] = pack_rgb(16, 20, 16, 1'b0);
        e.planes[2] = pack_rgb(16, 16, 12, 1'b1);
        e.planes[3] = pack_rgb(12, 16, 16, 1'b0);
        e.planes[4] = pack_rgb(16, 12, 16, 1'b1);
        e.planes[5] = pack_rgb(16, 16, 20, 1'b0);
        post_entry(e);
        wait_drained();

        // Filter off: entries pass through, dark or far alike.
        set_filter(1'b0);
        post_entry(uniform_entry(16'h0000, 16'h0000, 16'hFFFF));
        post_entry(uniform_entry(16'hFFFF, 16'h0000, 16'h0000));
        post_entry(uniform_entry(mid, mid, 16'h1234));
        post_mixed(40);
        wait_drained();

        // Filter on through the end of the first palette.
        set_filter(1'b1);
        post_mixed(to_palette_end());
        wait_drained();

        // A palette where every entry is cleared: the total wraps to zero.
        repeat (PaletteSize) begin
            e.base = dark_color();
            e.repl = 16'($urandom);
            foreach (e.planes[k]) begin
                e.planes[k] = 16'($urandom);
            end
            post_entry(e);
        end
        wait_drained();

        // A palette where nothing is cleared.
        repeat (PaletteSize) begin
            post_entry(clean_entry());
        end
        wait_drained();

        // Filter off across a palette end.
        set_filter(1'b0);
        post_mixed(to_palette_end() + 10);

        // Random phases with the enable flipped between them.
        phase_on = 1'b1;
        while (items_queued < TargetEntries) begin
            wait_drained();
            set_filter(phase_on);
            post_mixed($urandom_range(30, 160));
            phase_on = !phase_on;
        end
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && filtered_q.size() == 0) begin
            $display("palette_alpha_key_filter regression: pass");
        end else begin
            $display("palette_alpha_key_filter regression: fail");
        end
        $finish;
    end

endmodule
